// ===== rtl/statement_tokenizer_top_assert.svh =====
// ---------------------------------------------------------------------------
// statement tokenizer assertion macros
// clocked, reset-qualified assertion shorthands used by the result buffer rtl
// ---------------------------------------------------------------------------
`ifndef STATEMENT_TOKENIZER_TOP_ASSERT_SVH
`define STATEMENT_TOKENIZER_TOP_ASSERT_SVH

// condition implies expression in the same cycle
`define STT_ASSERT_SAME(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// condition implies expression in the next cycle
`define STT_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== rtl/stt_pkg.sv =====
// ---------------------------------------------------------------------------
// statement tokenizer package
// shared types, token kind codes and buffer sizing
// ---------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

    localparam int MAX_TOKEN_LEN_DEF = 99;
    localparam int LINE_LEN_DEF      = 1024;

    localparam int KIND_W  = 5;
    localparam int START_W = 10;
    localparam int TLEN_W  = 7;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_SYM,
        MODE_NUM,
        MODE_STR,
        MODE_EQ,
        MODE_DROP
    } mode_t;

    localparam logic [KIND_W-1:0] KIND_SYM     = 5'd0;
    localparam logic [KIND_W-1:0] KIND_NUM     = 5'd1;
    localparam logic [KIND_W-1:0] KIND_STR     = 5'd2;
    localparam logic [KIND_W-1:0] KIND_KW0     = 5'd3;
    localparam logic [KIND_W-1:0] KIND_PLUS    = 5'd11;
    localparam logic [KIND_W-1:0] KIND_COMMA   = 5'd12;
    localparam logic [KIND_W-1:0] KIND_MINUS   = 5'd13;
    localparam logic [KIND_W-1:0] KIND_NEWLINE = 5'd14;
    localparam logic [KIND_W-1:0] KIND_LPAREN  = 5'd15;
    localparam logic [KIND_W-1:0] KIND_RPAREN  = 5'd16;
    localparam logic [KIND_W-1:0] KIND_LBRACE  = 5'd17;
    localparam logic [KIND_W-1:0] KIND_RBRACE  = 5'd18;
    localparam logic [KIND_W-1:0] KIND_SEMI    = 5'd19;
    localparam logic [KIND_W-1:0] KIND_ASSIGN  = 5'd20;
    localparam logic [KIND_W-1:0] KIND_EQUAL   = 5'd21;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 5'd22;
    localparam logic [KIND_W-1:0] KIND_END     = 5'd23;

    localparam logic [1:0] COUNT_NONE = 2'd0;
    localparam logic [1:0] COUNT_ONE  = 2'd1;
    localparam logic [1:0] COUNT_TWO  = 2'd2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [START_W-1:0] start;
        logic [TLEN_W-1:0]  len;
        logic               last;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } step_result_t;

endpackage

`default_nettype wire

// ===== rtl/stt_char_if.sv =====
// ---------------------------------------------------------------------------
// character channel
// one statement character or end mark per request
// ---------------------------------------------------------------------------
`default_nettype none

interface stt_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_mark;

    modport source (output valid, output ch, output end_mark, input ready);
    modport sink   (input valid, input ch, input end_mark, output ready);
endinterface

`default_nettype wire

// ===== rtl/stt_token_if.sv =====
// ---------------------------------------------------------------------------
// token channel
// one token result per request
// ---------------------------------------------------------------------------
`default_nettype none

interface stt_token_if;
    logic                        valid;
    logic                        ready;
    logic [stt_pkg::KIND_W-1:0]  token_kind;
    logic [stt_pkg::START_W-1:0] token_start;
    logic [stt_pkg::TLEN_W-1:0]  token_len;
    logic                        last;

    modport source (output valid, output token_kind, output token_start,
                    output token_len, output last, input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_len, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/statement_tokenizer_top.sv =====
// ---------------------------------------------------------------------------
// statement tokenizer
// streaming lexer: one character per request in, token results out
// ---------------------------------------------------------------------------
//  channel    dir  payload                                   results
//  char_in    in   ch[7:0], end_mark                         -
//  token_out  out  token_kind, token_start, token_len, last  0 to 2 per char
//
//  one character per cycle while char_in.ready is high; scan state updates in the accept cycle
//  a character that closes one token and yields another produces two results
//  on the output side, absorbed by the four-entry result queue
//  char_in.ready drops while the queue holds more than two tokens
//  reset returns the scanner to idle at position zero with an empty queue
// ---------------------------------------------------------------------------
`default_nettype none

module statement_tokenizer_top #(
    parameter int MAX_TOKEN_LEN = stt_pkg::MAX_TOKEN_LEN_DEF,
    parameter int LINE_LEN      = stt_pkg::LINE_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    stt_char_if.sink    char_in,
    stt_token_if.source token_out
);

    logic                  step;
    logic                  room;
    logic                  out_valid;
    logic                  pop;
    stt_pkg::step_result_t result;
    stt_pkg::token_t       out_token;

    assign char_in.ready = room;
    assign step          = char_in.valid && room;
    assign pop           = out_valid && token_out.ready;

    stt_lexer #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .LINE_LEN      (LINE_LEN)
    ) u_lexer (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .ch       (char_in.ch),
        .end_mark (char_in.end_mark),
        .result   (result)
    );

    stt_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .result    (result),
        .room      (room),
        .out_valid (out_valid),
        .out_token (out_token),
        .pop       (pop)
    );

    assign token_out.valid       = out_valid;
    assign token_out.token_kind  = out_token.kind;
    assign token_out.token_start = out_token.start;
    assign token_out.token_len   = out_token.len;
    assign token_out.last        = out_token.last;

endmodule

`default_nettype wire

// ===== rtl/stt_lexer.sv =====
// ---------------------------------------------------------------------------
// statement tokenizer scan core
// scan state registers and single-pass next-state and token logic
// ---------------------------------------------------------------------------
`default_nettype none

module stt_lexer #(
    parameter int MAX_TOKEN_LEN = stt_pkg::MAX_TOKEN_LEN_DEF,
    parameter int LINE_LEN      = stt_pkg::LINE_LEN_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            ch,
    input  logic                  end_mark,
    output stt_pkg::step_result_t result
);

    localparam int POS_W = $clog2(LINE_LEN);
    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_LEN - 1);
    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_TOKEN_LEN);

    localparam logic [7:0] KW_TEXT [8][6] = '{
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", "i", "f"},
        '{"e", "l", "s", "e", 8'h00, 8'h00},
        '{"f", "u", "n", 8'h00, 8'h00, 8'h00},
        '{"a", "n", "d", 8'h00, 8'h00, 8'h00},
        '{"o", "r", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"n", "o", "t", 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [8] = '{3'd3, 3'd2, 3'd6, 3'd4, 3'd3, 3'd3, 3'd2, 3'd3};

    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = " ";
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_EQ     = "=";
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_COMMA  = ",";
    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_RPAREN = ")";
    localparam logic [7:0] CH_LBRACE = "{";
    localparam logic [7:0] CH_RBRACE = "}";
    localparam logic [7:0] CH_SEMI   = ";";

    function automatic logic is_alpha(input logic [7:0] c);
        return (c == "_") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic [7:0] narrow(input logic [7:0] hits, input logic [7:0] c,
                                          input logic [7:0] at);
        logic [7:0] res;
        res = hits;
        for (int k = 0; k < 8; k++)
        begin
            if (at >= {5'd0, KW_LEN[k]})
            begin
                res[k] = 1'b0;
            end
            else if (KW_TEXT[k][at[2:0]] != c)
            begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic logic [stt_pkg::KIND_W-1:0] sym_kind(input logic [7:0] hits,
                                                            input logic [7:0] len);
        logic [stt_pkg::KIND_W-1:0] kind;
        kind = stt_pkg::KIND_SYM;
        for (int k = 7; k >= 0; k--)
        begin
            if (hits[k] && (len == {5'd0, KW_LEN[k]}))
            begin
                kind = stt_pkg::KIND_KW0 + stt_pkg::KIND_W'(k);
            end
        end
        return kind;
    endfunction

    function automatic logic [stt_pkg::START_W-1:0] to_start(input logic [POS_W-1:0] p);
        logic [POS_W+stt_pkg::START_W-1:0] ext;
        ext = {{stt_pkg::START_W{1'b0}}, p};
        return ext[stt_pkg::START_W-1:0];
    endfunction

    function automatic logic [stt_pkg::TLEN_W-1:0] to_len(input logic [LEN_W-1:0] l);
        logic [LEN_W+stt_pkg::TLEN_W-1:0] ext;
        ext = {{stt_pkg::TLEN_W{1'b0}}, l};
        return ext[stt_pkg::TLEN_W-1:0];
    endfunction

    stt_pkg::mode_t   mode_reg, mode_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic [LEN_W-1:0] run_reg, run_next;
    logic [7:0]       hits_reg, hits_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    logic [LEN_W+7:0] run_ext;
    logic [7:0]       run8;
    logic [LEN_W-1:0] run_inc;
    logic             do_begin;
    logic             emit_a;
    logic             emit_b;
    stt_pkg::token_t  tok_a;
    stt_pkg::token_t  tok_b;

    assign run_ext = {8'd0, run_reg};
    assign run8    = run_ext[7:0];
    assign run_inc = run_reg + LEN_W'(1);

    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        run_next   = run_reg;
        hits_next  = hits_reg;
        pos_next   = pos_reg;
        do_begin   = 1'b0;
        emit_a     = 1'b0;
        emit_b     = 1'b0;
        tok_a      = '0;
        tok_b      = '0;

        if (end_mark)
        begin
            unique case (mode_reg)
                stt_pkg::MODE_SYM:
                begin
                    emit_a = 1'b1;
                    tok_a  = '{kind: sym_kind(hits_reg, run8), start: to_start(start_reg),
                               len: to_len(run_reg), last: 1'b0};
                end
                stt_pkg::MODE_NUM:
                begin
                    emit_a = 1'b1;
                    tok_a  = '{kind: stt_pkg::KIND_NUM, start: to_start(start_reg),
                               len: to_len(run_reg), last: 1'b0};
                end
                stt_pkg::MODE_STR:
                begin
                    emit_a = 1'b1;
                    tok_a  = '{kind: stt_pkg::KIND_ERROR, start: to_start(start_reg),
                               len: 7'd0, last: 1'b0};
                end
                stt_pkg::MODE_EQ:
                begin
                    emit_a = 1'b1;
                    tok_a  = '{kind: stt_pkg::KIND_ASSIGN, start: to_start(start_reg),
                               len: 7'd1, last: 1'b0};
                end
                default:
                begin
                    emit_a = 1'b0;
                end
            endcase
            emit_b     = 1'b1;
            tok_b      = '{kind: stt_pkg::KIND_END, start: to_start(pos_reg),
                           len: 7'd0, last: 1'b0};
            mode_next  = stt_pkg::MODE_IDLE;
            start_next = '0;
            run_next   = '0;
            hits_next  = 8'hff;
            pos_next   = '0;
        end
        else
        begin
            pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + POS_W'(1);
            unique case (mode_reg)
                stt_pkg::MODE_SYM:
                begin
                    if (is_alpha(ch) || is_digit(ch))
                    begin
                        if (run_reg >= LEN_MAX)
                        begin
                            emit_b    = 1'b1;
                            tok_b     = '{kind: stt_pkg::KIND_ERROR, start: to_start(start_reg),
                                          len: 7'd0, last: 1'b0};
                            mode_next = stt_pkg::MODE_DROP;
                        end
                        else
                        begin
                            hits_next = narrow(hits_reg, ch, run8);
                            run_next  = run_inc;
                        end
                    end
                    else
                    begin
                        emit_a   = 1'b1;
                        tok_a    = '{kind: sym_kind(hits_reg, run8), start: to_start(start_reg),
                                     len: to_len(run_reg), last: 1'b0};
                        do_begin = 1'b1;
                    end
                end
                stt_pkg::MODE_NUM:
                begin
                    if (is_digit(ch))
                    begin
                        if (run_reg >= LEN_MAX)
                        begin
                            emit_b    = 1'b1;
                            tok_b     = '{kind: stt_pkg::KIND_ERROR, start: to_start(start_reg),
                                          len: 7'd0, last: 1'b0};
                            mode_next = stt_pkg::MODE_DROP;
                        end
                        else
                        begin
                            run_next = run_inc;
                        end
                    end
                    else
                    begin
                        emit_a   = 1'b1;
                        tok_a    = '{kind: stt_pkg::KIND_NUM, start: to_start(start_reg),
                                     len: to_len(run_reg), last: 1'b0};
                        do_begin = 1'b1;
                    end
                end
                stt_pkg::MODE_STR:
                begin
                    if ((ch == CH_LF) || (run_reg >= LEN_MAX))
                    begin
                        emit_b    = 1'b1;
                        tok_b     = '{kind: stt_pkg::KIND_ERROR, start: to_start(start_reg),
                                      len: 7'd0, last: 1'b0};
                        mode_next = stt_pkg::MODE_DROP;
                    end
                    else
                    begin
                        run_next = run_inc;
                        if (ch == CH_QUOTE)
                        begin
                            mode_next = stt_pkg::MODE_IDLE;
                            emit_b    = 1'b1;
                            tok_b     = '{kind: stt_pkg::KIND_STR, start: to_start(start_reg),
                                          len: to_len(run_inc), last: 1'b0};
                        end
                    end
                end
                stt_pkg::MODE_EQ:
                begin
                    if (ch == CH_EQ)
                    begin
                        mode_next = stt_pkg::MODE_IDLE;
                        emit_b    = 1'b1;
                        tok_b     = '{kind: stt_pkg::KIND_EQUAL, start: to_start(start_reg),
                                      len: 7'd2, last: 1'b0};
                    end
                    else
                    begin
                        emit_a   = 1'b1;
                        tok_a    = '{kind: stt_pkg::KIND_ASSIGN, start: to_start(start_reg),
                                     len: 7'd1, last: 1'b0};
                        do_begin = 1'b1;
                    end
                end
                stt_pkg::MODE_DROP:
                begin
                    mode_next = stt_pkg::MODE_DROP;
                end
                default:
                begin
                    do_begin = 1'b1;
                end
            endcase

            // start of a new token at the current position
            if (do_begin)
            begin
                start_next = pos_reg;
                run_next   = LEN_W'(1);
                hits_next  = 8'hff;
                mode_next  = stt_pkg::MODE_IDLE;
                tok_b      = '{kind: stt_pkg::KIND_ERROR, start: to_start(pos_reg),
                               len: 7'd1, last: 1'b0};
                priority if ((ch == CH_SPACE) || (ch == CH_CR))
                begin
                    emit_b = 1'b0;
                end
                else if (is_alpha(ch))
                begin
                    hits_next = narrow(8'hff, ch, 8'd0);
                    mode_next = stt_pkg::MODE_SYM;
                end
                else if (is_digit(ch))
                begin
                    mode_next = stt_pkg::MODE_NUM;
                end
                else
                begin
                    emit_b = 1'b1;
                    unique case (ch)
                        CH_QUOTE:
                        begin
                            emit_b    = 1'b0;
                            mode_next = stt_pkg::MODE_STR;
                        end
                        CH_EQ:
                        begin
                            emit_b    = 1'b0;
                            mode_next = stt_pkg::MODE_EQ;
                        end
                        CH_PLUS:   tok_b.kind = stt_pkg::KIND_PLUS;
                        CH_COMMA:  tok_b.kind = stt_pkg::KIND_COMMA;
                        CH_MINUS:  tok_b.kind = stt_pkg::KIND_MINUS;
                        CH_LF:     tok_b.kind = stt_pkg::KIND_NEWLINE;
                        CH_LPAREN: tok_b.kind = stt_pkg::KIND_LPAREN;
                        CH_RPAREN: tok_b.kind = stt_pkg::KIND_RPAREN;
                        CH_LBRACE: tok_b.kind = stt_pkg::KIND_LBRACE;
                        CH_RBRACE: tok_b.kind = stt_pkg::KIND_RBRACE;
                        CH_SEMI:   tok_b.kind = stt_pkg::KIND_SEMI;
                        default:
                        begin
                            tok_b.len = 7'd0;
                            mode_next = stt_pkg::MODE_DROP;
                        end
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        result = '0;
        if (emit_a)
        begin
            result.first  = tok_a;
            result.second = tok_b;
            if (emit_b)
            begin
                result.count       = stt_pkg::COUNT_TWO;
                result.second.last = 1'b1;
            end
            else
            begin
                result.count      = stt_pkg::COUNT_ONE;
                result.first.last = 1'b1;
            end
        end
        else if (emit_b)
        begin
            result.count      = stt_pkg::COUNT_ONE;
            result.first      = tok_b;
            result.first.last = 1'b1;
        end
        else
        begin
            result.count = stt_pkg::COUNT_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= stt_pkg::MODE_IDLE;
            start_reg <= '0;
            run_reg   <= '0;
            hits_reg  <= 8'hff;
            pos_reg   <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            run_reg   <= run_next;
            hits_reg  <= hits_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stt_result_fifo.sv =====
// ---------------------------------------------------------------------------
// statement tokenizer result buffer
// small queue taking up to two tokens per cycle and releasing one when popped
// ---------------------------------------------------------------------------
`default_nettype none

`include "statement_tokenizer_top_assert.svh"

module stt_result_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  stt_pkg::step_result_t result,
    output logic                  room,
    output logic                  out_valid,
    output stt_pkg::token_t       out_token,
    input  logic                  pop
);

    localparam int DEPTH = stt_pkg::FIFO_DEPTH;
    localparam int PTR_W = stt_pkg::FIFO_PTR_W;
    localparam int CNT_W = stt_pkg::FIFO_CNT_W;

    stt_pkg::token_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] push_n;
    logic [PTR_W-1:0] wr_ptr_second;

    assign push_n        = push ? CNT_W'(result.count) : '0;
    assign wr_ptr_second = wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_next   = wr_ptr_reg + PTR_W'(push_n);
    assign rd_ptr_next   = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
    assign count_next    = count_reg + push_n - (pop ? CNT_W'(1) : CNT_W'(0));

    assign room      = count_reg <= CNT_W'(DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_token = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && (result.count != stt_pkg::COUNT_NONE))
        begin
            slot_reg[wr_ptr_reg] <= result.first;
        end
        if (push && (result.count == stt_pkg::COUNT_TWO))
        begin
            slot_reg[wr_ptr_second] <= result.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `STT_ASSERT_SAME(a_no_overflow, clk, rst_n, push, (4'(count_reg) + 4'(push_n)) <= 4'(DEPTH), "result buffer overflow")
    `STT_ASSERT_SAME(a_no_underflow, clk, rst_n, pop, count_reg != '0, "pop from empty result buffer")
    `STT_ASSERT_NEXT(a_pop_only, clk, rst_n, pop && !push, count_reg == $past(count_reg) - CNT_W'(1), "count not reduced by pop")

endmodule

`default_nettype wire
